@@ src/kmer_segment_dup_counter_defines.svh @@
// assertion macros for the segment duplicate counter
`ifndef KMER_SEGMENT_DUP_COUNTER_DEFINES_SVH
`define KMER_SEGMENT_DUP_COUNTER_DEFINES_SVH

`ifndef ASSERT_OFF
// checked with reset as the disable condition
`define KSDC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define KSDC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KSDC_ASSERT(lbl, clk, rst_n, prop, msg)
`define KSDC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ src/ksdc_pkg.sv @@
// constants, codes and helper functions of the segment duplicate counter
package ksdc_pkg;

	localparam int SEGMENT_LEN = 8;
	localparam int MAX_ROWS    = 64;
	localparam int HIST_DEPTH  = 4096;
	localparam int COUNT_WIDTH = 32;

	localparam int LEN_W      = 10;
	localparam int CHAR_W     = 8;
	localparam int BIN_W      = 12;
	localparam int OP_W       = 2;
	localparam int VAL_W      = 32;
	localparam int LEN_RESET  = 150;

	localparam int CODE_BITS   = 2 * SEGMENT_LEN;
	localparam int ROW_CELLS   = 1 << CODE_BITS;
	localparam int COUNT_CELLS = MAX_ROWS * ROW_CELLS;
	localparam int OFF_W       = (SEGMENT_LEN > 1) ? $clog2(SEGMENT_LEN) : 1;
	localparam int ROW_AW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CNT_AW      = ROW_AW + CODE_BITS;
	localparam int ROW_LIM     = ((1 << LEN_W) - 1) / SEGMENT_LEN + 1;
	localparam int ROW_W       = $clog2(((ROW_LIM > MAX_ROWS) ? ROW_LIM : MAX_ROWS) + 1);
	localparam int HIST_AW     = $clog2(HIST_DEPTH);
	localparam int CLR_CNT     = (COUNT_CELLS > HIST_DEPTH) ? COUNT_CELLS : HIST_DEPTH;
	localparam int CLR_W       = $clog2(CLR_CNT);

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
	localparam logic [VAL_W-1:0]       VAL_MAX   = '1;

	typedef enum logic [OP_W-1:0] {
		OP_COUNT = 2'd0,
		OP_QUERY = 2'd1,
		OP_BIN   = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef enum logic [OP_W-1:0] {
		KIND_COUNTED = 2'd0,
		KIND_QUERIED = 2'd1,
		KIND_BIN     = 2'd2,
		KIND_UNUSED  = 2'd3
	} kind_t;

	// 2-bit nucleotide code, anything unknown maps to zero like A and N
	function automatic logic [1:0] base_code(input logic [CHAR_W-1:0] ch);
		logic [1:0] c;
		unique case (ch)
			8'h54, 8'h74: c = 2'd1; // T t
			8'h47, 8'h67: c = 2'd2; // G g
			8'h43, 8'h63: c = 2'd3; // C c
			default:      c = 2'd0;
		endcase
		return c;
	endfunction

endpackage

@@ src/kmer_segment_dup_counter.sv @@
// per-read segment counter with minimum-count duplicate histogram
//
// input stream: s_axis carries one base per item. tuser is the opcode
// (count pass, query pass, histogram read), tlast ends the read, tdata holds
// the base character and the histogram bin index. the output stream m_axis
// returns one item at the end of each read and for each bin read; tuser is the
// result kind, tdata the minimum count, the bin value and the read total.
// cfg writes read_length (default 150); write it only while the block is idle.
// flow: a base that does not close a segment is taken while idle; one that closes
// a segment also needs a counter memory read, then modify and write back. at the
// read end each remaining row gets its own counter read-modify-write, then the
// result is posted, after a histogram read and update when a query's minimum is above one.
// a bin read needs a histogram read. the counter memory read-modify-write sets the pace.
// reset: both memories are swept to zero, one entry per cycle; no item is taken
// meanwhile, config writes still are.
// output: results sit in an output register; while the receiver stalls the
// block keeps taking bases and waits only when the next result is ready.
`include "kmer_segment_dup_counter_defines.svh"

module kmer_segment_dup_counter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // base_char[7:0], bin_index[19:8], zero fill
	input  logic [ksdc_pkg::OP_W-1:0] s_axis_tuser, // opcode[1:0]
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata,  // min_count[31:0], bin_count[63:32], reads_total[95:64]
	output logic [ksdc_pkg::OP_W-1:0] m_axis_tuser, // result_kind[1:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [ksdc_pkg::LEN_W-1:0] cfg_data
);
	import ksdc_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_RD, S_MOD, S_FILL, S_END, S_HRD, S_HMOD, S_OUT
	} state_t;

	state_t state_q;

	logic [LEN_W-1:0]     len_q;
	logic [LEN_W-1:0]     pos_q;
	logic [OFF_W-1:0]     off_q;
	logic [ROW_W-1:0]     seg_row_q;
	logic [CODE_BITS-1:0] code_q;
	logic [VAL_W-1:0]     min_q;
	logic [VAL_W-1:0]     reads_q;
	logic                 query_q;
	logic                 last_q;
	logic                 bin_op_q;
	logic                 bin_ok_q;
	logic [ROW_W-1:0]     touch_row_q;
	logic [CODE_BITS-1:0] touch_code_q;
	logic [HIST_AW-1:0]   hidx_q;
	logic [VAL_W-1:0]     res_bin_q;
	logic [CLR_W-1:0]     clr_q;

	logic                 out_valid_q;
	logic [OP_W-1:0]      out_kind_q;
	logic [VAL_W-1:0]     out_min_q;
	logic [VAL_W-1:0]     out_bin_q;
	logic [VAL_W-1:0]     out_reads_q;

	// memories
	logic [COUNT_WIDTH-1:0] cnt_mem [COUNT_CELLS];
	logic [VAL_W-1:0]       hist_mem [HIST_DEPTH];
	logic [COUNT_WIDTH-1:0] cnt_rd;
	logic [VAL_W-1:0]       hist_rd;

	logic                   cnt_re, cnt_we;
	logic [CNT_AW-1:0]      cnt_raddr, cnt_waddr;
	logic [COUNT_WIDTH-1:0] cnt_wdata;
	logic                   hist_re, hist_we;
	logic [HIST_AW-1:0]     hist_waddr;
	logic [VAL_W-1:0]       hist_wdata;

	logic                   clearing;
	logic                   in_accept;
	logic [CHAR_W-1:0]      in_char;
	logic [BIN_W-1:0]       in_bin;
	logic [CODE_BITS-1:0]   new_code;
	logic                   seg_done;
	logic                   pos_open;
	logic                   out_free;

	// row r exists when r is below MAX_ROWS and r*SEGMENT_LEN is below the read length
	function automatic logic row_valid(input logic [ROW_W-1:0] r, input logic [LEN_W-1:0] len);
		return (32'(r) < MAX_ROWS) && ((32'(r) * SEGMENT_LEN) < 32'(len));
	endfunction

	assign clearing      = (state_q == S_CLEAR);
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign in_char       = s_axis_tdata[CHAR_W-1:0];
	assign in_bin        = s_axis_tdata[CHAR_W +: BIN_W];
	assign cfg_ready     = 1'b1;
	assign out_free      = !out_valid_q || m_axis_tready;

	assign pos_open = (pos_q < len_q);
	assign new_code = code_q | (CODE_BITS'(base_code(in_char)) << {off_q, 1'b0});
	assign seg_done = (32'(off_q) == SEGMENT_LEN - 1);

	assign cnt_re    = (state_q == S_RD) && row_valid(touch_row_q, len_q);
	assign cnt_raddr = {touch_row_q[ROW_AW-1:0], touch_code_q};
	assign cnt_we    = clearing ? (32'(clr_q) < COUNT_CELLS) : ((state_q == S_MOD) && !query_q);
	assign cnt_waddr = clearing ? CNT_AW'(clr_q) : cnt_raddr;
	assign cnt_wdata = clearing ? '0 : ((cnt_rd == COUNT_MAX) ? cnt_rd : cnt_rd + 1'b1);

	assign hist_re    = (state_q == S_HRD);
	assign hist_we    = clearing ? (32'(clr_q) < HIST_DEPTH) : ((state_q == S_HMOD) && !bin_op_q);
	assign hist_waddr = clearing ? HIST_AW'(clr_q) : hidx_q;
	assign hist_wdata = clearing ? '0 : ((hist_rd == VAL_MAX) ? hist_rd : hist_rd + 1'b1);

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
		if (cnt_re) begin
			cnt_rd <= cnt_mem[cnt_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[hist_waddr] <= hist_wdata;
		end
		if (hist_re) begin
			hist_rd <= hist_mem[hidx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			len_q       <= LEN_W'(LEN_RESET);
			pos_q       <= '0;
			off_q       <= '0;
			seg_row_q   <= '0;
			code_q      <= '0;
			min_q       <= VAL_MAX;
			reads_q     <= '0;
			query_q     <= 1'b0;
			last_q      <= 1'b0;
			bin_op_q    <= 1'b0;
			bin_ok_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				len_q <= cfg_data;
			end
			// in S_OUT a taken item is replaced by the next result below
			if (m_axis_tready && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_W'(CLR_CNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_accept) begin
						unique case (opcode_t'(s_axis_tuser))
							OP_BIN: begin
								bin_op_q <= 1'b1;
								bin_ok_q <= (32'(in_bin) < HIST_DEPTH);
								hidx_q   <= HIST_AW'(in_bin);
								state_q  <= S_HRD;
							end
							OP_COUNT, OP_QUERY: begin
								bin_op_q <= 1'b0;
								query_q  <= (opcode_t'(s_axis_tuser) == OP_QUERY);
								last_q   <= s_axis_tlast;
								if (pos_open && seg_done) begin
									state_q <= S_RD;
								end else begin
									state_q <= s_axis_tlast ? S_FILL : S_IDLE;
								end
								if (pos_open) begin
									pos_q <= pos_q + 1'b1;
									if (seg_done) begin
										touch_row_q  <= seg_row_q;
										touch_code_q <= new_code;
										code_q       <= '0;
										off_q        <= '0;
										seg_row_q    <= seg_row_q + 1'b1;
									end else begin
										code_q <= new_code;
										off_q  <= off_q + 1'b1;
									end
								end
							end
							OP_NONE: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_RD: begin
					if (cnt_re) begin
						state_q <= S_MOD;
					end else begin
						state_q <= last_q ? S_FILL : S_IDLE;
					end
				end
				S_MOD: begin
					// count pass writes back through cnt_we, query pass folds the minimum
					if (query_q && (32'(cnt_rd) < min_q)) begin
						min_q <= 32'(cnt_rd);
					end
					state_q <= last_q ? S_FILL : S_IDLE;
				end
				S_FILL: begin
					// open segment first, then code zero for every remaining row
					if (row_valid(seg_row_q, len_q)) begin
						touch_row_q  <= seg_row_q;
						touch_code_q <= code_q;
						code_q       <= '0;
						seg_row_q    <= seg_row_q + 1'b1;
						state_q      <= S_RD;
					end else begin
						state_q <= S_END;
					end
				end
				S_END: begin
					if (!query_q) begin
						if (reads_q != VAL_MAX) begin
							reads_q <= reads_q + 1'b1;
						end
						state_q <= S_OUT;
					end else if (min_q > 32'd1) begin
						hidx_q  <= (min_q >= HIST_DEPTH) ? HIST_AW'(HIST_DEPTH - 1)
						                                 : HIST_AW'(min_q);
						state_q <= S_HRD;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_HRD: begin
					state_q <= S_HMOD;
				end
				S_HMOD: begin
					res_bin_q <= bin_ok_q ? hist_rd : '0;
					state_q   <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_reads_q <= reads_q;
						if (bin_op_q) begin
							out_kind_q <= KIND_BIN;
							out_min_q  <= '0;
							out_bin_q  <= res_bin_q;
						end else begin
							out_kind_q <= query_q ? KIND_QUERIED : KIND_COUNTED;
							out_min_q  <= query_q ? min_q : '0;
							out_bin_q  <= '0;
							pos_q      <= '0;
							off_q      <= '0;
							seg_row_q  <= '0;
							code_q     <= '0;
							min_q      <= VAL_MAX;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tdata  = {out_reads_q, out_bin_q, out_min_q};

	// read and write-back of the counter memory never hit one entry in one cycle
	`KSDC_ASSERT(a_cnt_no_overlap, clk, arst_n, (cnt_re && cnt_we) |-> (cnt_raddr != cnt_waddr), "counter read and write collide")
	// a counter write-back always follows its own read
	`KSDC_ASSERT(a_cnt_wb_after_rd, clk, arst_n, (cnt_we && !clearing) |-> ($past(state_q) == S_RD), "counter write without read")
	// a histogram increment always follows its own read
	`KSDC_ASSERT(a_hist_wb_after_rd, clk, arst_n, (hist_we && !clearing) |-> ($past(state_q) == S_HRD), "histogram write without read")
	// a finished read leaves the per-read state cleared
	`KSDC_ASSERT(a_read_state_cleared, clk, arst_n, ((state_q == S_OUT) && out_free && !bin_op_q) |=> ((min_q == VAL_MAX) && (pos_q == '0) && (code_q == '0)), "read state not cleared")
	// no item is taken during the clearing sweep
	`KSDC_ASSERT_ALWAYS(a_no_accept_clear, clk, clearing |-> !in_accept, "item taken while clearing")

endmodule

@@ sim/testbench.sv @@
// testbench for the segment duplicate counter: scoreboard class plus stream drivers
`timescale 1ns / 1ps

module testbench;
	import ksdc_pkg::*;

	typedef struct packed {
		logic [OP_W-1:0]  kind;
		logic [VAL_W-1:0] min_count;
		logic [VAL_W-1:0] bin_count;
		logic [VAL_W-1:0] reads_total;
	} dup_result_t;

	// mirrors the counter memory, histogram and per-read state of the block
	class dup_scoreboard;
		logic [COUNT_WIDTH-1:0] seg_count [int];
		logic [VAL_W-1:0]       hist [HIST_DEPTH];
		logic [CODE_BITS-1:0]   seg_code;
		logic [LEN_W-1:0]       base_pos;
		logic [VAL_W-1:0]       run_min;
		logic [VAL_W-1:0]       read_total;
		logic [LEN_W-1:0]       read_len;
		dup_result_t            expected_q [$];
		int                     errors;

		function new();
			foreach (hist[i])
				hist[i] = '0;
			seg_code   = '0;
			base_pos   = '0;
			run_min    = VAL_MAX;
			read_total = '0;
			read_len   = LEN_W'(LEN_RESET);
			errors     = 0;
		endfunction

		function void set_len(logic [LEN_W-1:0] len);
			read_len = len;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function logic [1:0] nt_code(logic [CHAR_W-1:0] ch);
			case (ch)
				"T", "t": return 2'd1;
				"G", "g": return 2'd2;
				"C", "c": return 2'd3;
				default:  return 2'd0;
			endcase
		endfunction

		// count pass bumps the cell, query pass folds it into the running minimum
		function void fold_segment(opcode_t op, int row, logic [CODE_BITS-1:0] code, int rows);
			int key;
			logic [COUNT_WIDTH-1:0] cnt;
			if (row >= rows)
				return;
			key = row * ROW_CELLS + int'(code);
			cnt = seg_count.exists(key) ? seg_count[key] : '0;
			if (op == OP_COUNT) begin
				if (cnt != COUNT_MAX)
					seg_count[key] = cnt + 1'b1;
			end else if (VAL_W'(cnt) < run_min) begin
				run_min = VAL_W'(cnt);
			end
		endfunction

		function void note_input(opcode_t op, logic [CHAR_W-1:0] ch, logic last,
				logic [BIN_W-1:0] bin);
			dup_result_t res;
			int rows, next, off, r, b;
			res = '0;
			if (op == OP_NONE)
				return;
			if (op == OP_BIN) begin
				res.kind        = KIND_BIN;
				res.bin_count   = (int'(bin) < HIST_DEPTH) ? hist[bin] : '0;
				res.reads_total = read_total;
				expected_q.push_back(res);
				return;
			end
			rows = (int'(read_len) + SEGMENT_LEN - 1) / SEGMENT_LEN;
			if (rows > MAX_ROWS)
				rows = MAX_ROWS;
			if (base_pos < read_len) begin
				off = int'(base_pos) % SEGMENT_LEN;
				seg_code = seg_code | (CODE_BITS'(nt_code(ch)) << (2 * off));
				base_pos = base_pos + 1'b1;
				if (int'(base_pos) % SEGMENT_LEN == 0) begin
					fold_segment(op, (int'(base_pos) - 1) / SEGMENT_LEN, seg_code, rows);
					seg_code = '0;
				end
			end
			if (!last)
				return;
			next = int'(base_pos) / SEGMENT_LEN;
			if (int'(base_pos) % SEGMENT_LEN != 0) begin
				fold_segment(op, next, seg_code, rows);
				next++;
			end
			// rows the short read never reached count as code zero
			for (r = next; r < rows; r++)
				fold_segment(op, r, '0, rows);
			if (op == OP_COUNT) begin
				if (read_total != VAL_MAX)
					read_total = read_total + 1'b1;
				res.kind = KIND_COUNTED;
			end else begin
				if (run_min > 1) begin
					b = (run_min >= HIST_DEPTH) ? HIST_DEPTH - 1 : int'(run_min);
					if (hist[b] != VAL_MAX)
						hist[b] = hist[b] + 1'b1;
				end
				res.kind      = KIND_QUERIED;
				res.min_count = run_min;
			end
			res.reads_total = read_total;
			expected_q.push_back(res);
			base_pos = '0;
			seg_code = '0;
			run_min  = VAL_MAX;
		endfunction

		function void check_result(logic [OP_W-1:0] kind, logic [95:0] data);
			dup_result_t exp_res;
			if (expected_q.size() == 0) begin
				$error("unexpected result: kind %0d data %h", kind, data);
				errors++;
				return;
			end
			exp_res = expected_q.pop_front();
			if (kind !== exp_res.kind) begin
				$error("result_kind mismatch: expected %0d, actual %0d", exp_res.kind, kind);
				errors++;
			end
			if (data[31:0] !== exp_res.min_count) begin
				$error("min_count mismatch: expected %0d, actual %0d",
					exp_res.min_count, data[31:0]);
				errors++;
			end
			if (data[63:32] !== exp_res.bin_count) begin
				$error("bin_count mismatch: expected %0d, actual %0d",
					exp_res.bin_count, data[63:32]);
				errors++;
			end
			if (data[95:64] !== exp_res.reads_total) begin
				$error("reads_total mismatch: expected %0d, actual %0d",
					exp_res.reads_total, data[95:64]);
				errors++;
			end
		endfunction
	endclass

	// reset sweep covers the whole counter memory before any item is taken
	localparam longint CYCLE_LIMIT = 64'd4194304 * 64'd4;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [23:0]          s_axis_tdata = '0;
	logic [OP_W-1:0]      s_axis_tuser = '0;
	logic                 s_axis_tlast = 1'b0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [95:0]          m_axis_tdata;
	logic [OP_W-1:0]      m_axis_tuser;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [LEN_W-1:0]     cfg_data = '0;

	dup_scoreboard sb = new();
	bit            gaps_on = 1'b1;
	longint        cycle_count = 0;
	logic [CHAR_W-1:0] pool [3][520];

	kmer_segment_dup_counter DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("kmer_segment_dup_counter regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= !gaps_on || ($urandom_range(99) >= 34);
	end

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready === 1'b1)
			sb.note_input(opcode_t'(s_axis_tuser), s_axis_tdata[7:0], s_axis_tlast,
				s_axis_tdata[19:8]);
		if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
			sb.check_result(m_axis_tuser, m_axis_tdata);
	end

	task automatic send_item(opcode_t op, logic [CHAR_W-1:0] ch, logic last,
			logic [BIN_W-1:0] bin);
		while (gaps_on && $urandom_range(99) < 34) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {4'b0, bin, ch};
		s_axis_tlast  <= last;
		do
			@(posedge clk);
		while (s_axis_tready !== 1'b1);
	endtask

	task automatic write_len(logic [LEN_W-1:0] len);
		cfg_valid <= 1'b1;
		cfg_data  <= len;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		sb.set_len(len);
	endtask

	// hold the input until every result is back, then let trailing bases settle
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic send_string(opcode_t op, string s);
		for (int i = 0; i < s.len(); i++)
			send_item(op, s[i], i == s.len() - 1, BIN_W'($urandom_range(4095)));
	endtask

	function automatic logic [CHAR_W-1:0] rand_char();
		string alpha = "ACGTacgtNn";
		if ($urandom_range(99) < 85)
			return alpha[$urandom_range(9)];
		return CHAR_W'($urandom_range(255));
	endfunction

	task automatic send_read(opcode_t op, int n, int src, bit mixed);
		opcode_t o;
		logic [CHAR_W-1:0] ch;
		for (int i = 0; i < n; i++) begin
			o = op;
			if (mixed && $urandom_range(1))
				o = (op == OP_COUNT) ? OP_QUERY : OP_COUNT;
			ch = pool[src][i];
			if ($urandom_range(19) == 0)
				ch = CHAR_W'($urandom_range(255));
			send_item(o, ch, i == n - 1, BIN_W'($urandom_range(4095)));
		end
	endtask

	task automatic run_phase(int len, int n_reads);
		int pick, n, full;
		opcode_t op;
		drain_results();
		write_len(LEN_W'(len));
		foreach (pool[s, i])
			pool[s][i] = rand_char();
		for (int k = 0; k < n_reads; k++) begin
			pick = $urandom_range(99);
			op   = $urandom_range(1) ? OP_QUERY : OP_COUNT;
			// long reads stay short so each read end fills most rows
			full = (len > 64) ? $urandom_range(1, 40) : len;
			if (pick < 55) begin
				send_read(OP_COUNT, full, $urandom_range(2), 1'b0);
			end else if (pick < 80) begin
				send_read(OP_QUERY, full, $urandom_range(2), 1'b0);
			end else if (pick < 88) begin
				n = (full > 1) ? $urandom_range(1, full - 1) : 1;
				send_read(op, n, $urandom_range(2), 1'b0);
			end else if (pick < 93) begin
				n = (len > 64) ? full : len + $urandom_range(1, 3);
				send_read(op, n, $urandom_range(2), 1'b0);
			end else if (pick < 96) begin
				send_read(op, full, $urandom_range(2), 1'b1);
			end else begin
				send_item(OP_NONE, CHAR_W'($urandom_range(255)), 1'($urandom_range(1)),
					BIN_W'($urandom_range(4095)));
			end
			if ($urandom_range(99) < 20) begin
				case ($urandom_range(2))
					0:       send_item(OP_BIN, rand_char(), 1'($urandom_range(1)),
							BIN_W'($urandom_range(6)));
					1:       send_item(OP_BIN, rand_char(), 1'($urandom_range(1)),
							BIN_W'(HIST_DEPTH - 1));
					default: send_item(OP_BIN, rand_char(), 1'($urandom_range(1)),
							BIN_W'($urandom_range(4095)));
				endcase
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// two rows: one full segment, one partial with an unknown character
		write_len(LEN_W'(10));
		send_string(OP_COUNT, string'({"ATGCatgcN", 8'hFF}));
		send_string(OP_QUERY, string'({"ATGCatgcN", 8'hFF}));
		// short read, missing positions and row fill as code zero
		send_string(OP_COUNT, "g");
		send_string(OP_QUERY, "g");
		send_item(OP_NONE, 8'hFF, 1'b1, '1);
		send_item(OP_BIN, 8'h00, 1'b0, BIN_W'(1));
		send_item(OP_BIN, 8'h00, 1'b1, BIN_W'(HIST_DEPTH - 1));

		// no rows: the query keeps the all-ones minimum and lands in the top bin
		drain_results();
		write_len('0);
		send_item(OP_COUNT, "C", 1'b1, '0);
		send_item(OP_QUERY, "G", 1'b1, '0);
		send_item(OP_BIN, "A", 1'b0, BIN_W'(HIST_DEPTH - 1));
		send_item(OP_BIN, "A", 1'b0, '0);

		run_phase(1, 20);
		gaps_on = 1'b0;
		run_phase(8, 20);
		gaps_on = 1'b1;
		run_phase(13, 8);
		run_phase(5, 12);
		run_phase(512, 8);
		run_phase(3, 15);

		drain_results();
		repeat (300) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("kmer_segment_dup_counter regression: pass");
		else
			$display("kmer_segment_dup_counter regression: fail");
		$finish;
	end

endmodule
